FILE: hdl/tbcm_pkg.sv
package tbcm_pkg;

  localparam int unsigned NumTrig = 8;
  localparam int unsigned CntW    = 20;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned RowW    = NumTrig * CntW;
  localparam int unsigned ProdW   = 2 * CntW;
  localparam int unsigned WideW   = 4 * CntW;
  localparam int unsigned RootW   = WideW + 34;
  localparam int unsigned QW      = 16;

  typedef struct packed {
    logic       action;
    logic [7:0] trigger_bits;
    logic [2:0] row_trigger;
    logic [2:0] col_trigger;
  } tbcm_in_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic               defined;
  } tbcm_out_t;

  localparam logic ActEvent = 1'b0;
  localparam logic ActRead  = 1'b1;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_VI,
    MUL_VJ,
    MUL_A,
    MUL_B,
    MUL_P_LL,
    MUL_P_LH,
    MUL_P_HL,
    MUL_P_HH,
    MUL_M_LL,
    MUL_M_LH,
    MUL_M_HL,
    MUL_M_HH
  } mul_op_e;

  typedef enum logic [1:0] {
    RS_ROW_IN,
    RS_ROW,
    RS_COL,
    RS_SWEEP
  } rd_sel_e;

  typedef struct packed {
    logic            take;
    rd_sel_e         rsel;
    logic [IdxW-1:0] sweep_raddr;
    logic            wr_en;
    logic [IdxW-1:0] waddr;
    logic            cap_row;
    logic            cap_nj;
    mul_op_e         mul_op;
    logic            mag_en;
    logic            root_init;
    logic            root_step;
    logic            out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
  } dp_stat_t;

endpackage

FILE: hdl/tbcm_ram.sv
module tbcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tbcm_dp.sv
module tbcm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbcm_pkg::tbcm_in_t  in_item_i,
  input  tbcm_pkg::ctrl_cmd_t cmd_i,
  output tbcm_pkg::dp_stat_t  stat_o,
  output tbcm_pkg::tbcm_out_t out_item_o
);
  import tbcm_pkg::*;

  logic [CntW-1:0]  n_q;
  logic [7:0]       bits_q;
  logic [IdxW-1:0]  row_q, col_q;
  logic [NumTrig-1:0] row_vld_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  raddr;
  logic [RowW-1:0]  rdata, row_data, wdata;
  logic [CntW-1:0]  ni_q, nj_q, nij_q;
  logic [CntW-1:0]  opa, opb;
  logic [ProdW-1:0] p_q;
  mul_op_e          op_q;
  logic [ProdW-1:0] vi_q, vj_q, a_q, b_q, mag_q;
  logic             neg_q, def_q;
  logic [WideW-1:0] pacc_q, macc_q, part;
  logic [RootW-1:0] s_q, tb_q, pb_q, cand, rhs;
  logic             fit;
  logic [QW-1:0]    q_q;
  tbcm_out_t        out_d, out_q;

  always_comb begin
    unique case (cmd_i.rsel)
      RS_ROW_IN: raddr = in_item_i.row_trigger;
      RS_ROW:    raddr = row_q;
      RS_COL:    raddr = col_q;
      RS_SWEEP:  raddr = cmd_i.sweep_raddr;
      default:   raddr = row_q;
    endcase
  end

  tbcm_ram #(
    .Width(RowW),
    .Depth(NumTrig)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // a row never written reads as all zero
  assign row_data = rd_vld_q ? rdata : '0;

  always_comb begin
    for (int c = 0; c < NumTrig; c++) begin
      wdata[c*CntW +: CntW] = row_data[c*CntW +: CntW]
                              + CntW'(bits_q[cmd_i.waddr] & bits_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      op_q      <= MUL_NONE;
    end else begin
      rd_vld_q <= row_vld_q[raddr];
      op_q     <= cmd_i.mul_op;
      if (cmd_i.wr_en) begin
        row_vld_q[cmd_i.waddr] <= 1'b1;
      end
      if (cmd_i.take && in_item_i.action == ActEvent && !stat_o.full) begin
        n_q <= n_q + CntW'(1);
      end
    end
  end

  assign stat_o.full = &n_q;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_op)
      MUL_VI:   begin opa = ni_q; opb = n_q - ni_q; end
      MUL_VJ:   begin opa = nj_q; opb = n_q - nj_q; end
      MUL_A:    begin opa = n_q;  opb = nij_q; end
      MUL_B:    begin opa = ni_q; opb = nj_q; end
      MUL_P_LL: begin opa = vi_q[CntW-1:0];     opb = vj_q[CntW-1:0]; end
      MUL_P_LH: begin opa = vi_q[CntW-1:0];     opb = vj_q[ProdW-1:CntW]; end
      MUL_P_HL: begin opa = vi_q[ProdW-1:CntW]; opb = vj_q[CntW-1:0]; end
      MUL_P_HH: begin opa = vi_q[ProdW-1:CntW]; opb = vj_q[ProdW-1:CntW]; end
      MUL_M_LL: begin opa = mag_q[CntW-1:0];     opb = mag_q[CntW-1:0]; end
      MUL_M_LH: begin opa = mag_q[CntW-1:0];     opb = mag_q[ProdW-1:CntW]; end
      MUL_M_HL: begin opa = mag_q[ProdW-1:CntW]; opb = mag_q[CntW-1:0]; end
      MUL_M_HH: begin opa = mag_q[ProdW-1:CntW]; opb = mag_q[ProdW-1:CntW]; end
      default:  begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    unique case (op_q)
      MUL_P_LH, MUL_P_HL, MUL_M_LH, MUL_M_HL: part = {{ProdW{1'b0}}, p_q} << CntW;
      MUL_P_HH, MUL_M_HH:                     part = {{ProdW{1'b0}}, p_q} << ProdW;
      default:                                part = {{ProdW{1'b0}}, p_q};
    endcase
  end

  assign cand = s_q + tb_q + pb_q;
  assign rhs  = {4'b0, macc_q, 30'b0};
  assign fit  = cand <= rhs;

  always_comb begin
    out_d.defined     = def_q;
    if (!def_q) begin
      out_d.correlation = '0;
    end else if (neg_q) begin
      out_d.correlation = -$signed(q_q);
    end else if (q_q[QW-1]) begin
      out_d.correlation = 16'sh7FFF;
    end else begin
      out_d.correlation = $signed(q_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      bits_q <= in_item_i.trigger_bits;
      row_q  <= in_item_i.row_trigger;
      col_q  <= in_item_i.col_trigger;
    end
    if (cmd_i.cap_row) begin
      ni_q  <= row_data[row_q*CntW +: CntW];
      nij_q <= row_data[col_q*CntW +: CntW];
    end
    if (cmd_i.cap_nj) begin
      nj_q <= row_data[col_q*CntW +: CntW];
    end
    p_q <= opa * opb;
    unique case (op_q)
      MUL_VI: vi_q <= p_q;
      MUL_VJ: vj_q <= p_q;
      MUL_A:  a_q  <= p_q;
      MUL_B:  b_q  <= p_q;
      MUL_P_LL, MUL_P_LH, MUL_P_HL, MUL_P_HH: pacc_q <= pacc_q + part;
      MUL_M_LL, MUL_M_LH, MUL_M_HL, MUL_M_HH: macc_q <= macc_q + part;
      default: ;
    endcase
    if (cmd_i.mag_en) begin
      neg_q  <= a_q < b_q;
      mag_q  <= (a_q < b_q) ? b_q - a_q : a_q - b_q;
      def_q  <= (n_q != '0) && (vi_q != '0) && (vj_q != '0);
      pacc_q <= '0;
      macc_q <= '0;
    end
    // shift-and-add root search: s = q^2*P, tb = q*P aligned to the current bit
    if (cmd_i.root_init) begin
      s_q  <= '0;
      tb_q <= '0;
      pb_q <= {4'b0, pacc_q, 30'b0};
      q_q  <= '0;
    end else if (cmd_i.root_step) begin
      if (fit) begin
        s_q <= cand;
      end
      tb_q <= (tb_q >> 1) + (fit ? pb_q : '0);
      pb_q <= pb_q >> 2;
      q_q  <= {q_q[QW-2:0], fit};
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: hdl/tbcm_ctrl.sv
module tbcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbcm_pkg::tbcm_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tbcm_pkg::dp_stat_t  stat_i,
  output tbcm_pkg::ctrl_cmd_t cmd_o
);
  import tbcm_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    EV_SW,
    RD_COL,
    RD_NJ,
    MUL,
    MWAIT,
    MAG,
    PMUL,
    PWAIT,
    RINIT,
    ROOT,
    DONE
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free;

  assign in_stall_o = state_q != IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.rsel  = RS_ROW;
    cmd_o.mul_op = MUL_NONE;
    unique case (state_q)
      IDLE: begin
        cmd_o.rsel = (in_item_i.action == ActRead) ? RS_ROW_IN : RS_SWEEP;
        if (accept) begin
          cmd_o.take = 1'b1;
          cnt_d      = '0;
          if (in_item_i.action == ActRead) begin
            state_d = RD_COL;
          end else if (!stat_i.full) begin
            state_d = EV_SW;
          end
        end
      end
      EV_SW: begin
        // write back row cnt while the next row is read
        cmd_o.wr_en       = 1'b1;
        cmd_o.waddr       = cnt_q[IdxW-1:0];
        cmd_o.rsel        = RS_SWEEP;
        cmd_o.sweep_raddr = cnt_q[IdxW-1:0] + IdxW'(1);
        cnt_d             = cnt_q + 4'd1;
        if (cnt_q == 4'(NumTrig - 1)) begin
          state_d = IDLE;
        end
      end
      RD_COL: begin
        cmd_o.rsel    = RS_COL;
        cmd_o.cap_row = 1'b1;
        state_d       = RD_NJ;
      end
      RD_NJ: begin
        cmd_o.cap_nj = 1'b1;
        state_d      = MUL;
      end
      MUL: begin
        unique case (cnt_q[1:0])
          2'd0:    cmd_o.mul_op = MUL_VI;
          2'd1:    cmd_o.mul_op = MUL_VJ;
          2'd2:    cmd_o.mul_op = MUL_A;
          default: cmd_o.mul_op = MUL_B;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = MWAIT;
        end
      end
      MWAIT: state_d = MAG;
      MAG: begin
        cmd_o.mag_en = 1'b1;
        cnt_d        = '0;
        state_d      = PMUL;
      end
      PMUL: begin
        unique case (cnt_q[2:0])
          3'd0:    cmd_o.mul_op = MUL_P_LL;
          3'd1:    cmd_o.mul_op = MUL_P_LH;
          3'd2:    cmd_o.mul_op = MUL_P_HL;
          3'd3:    cmd_o.mul_op = MUL_P_HH;
          3'd4:    cmd_o.mul_op = MUL_M_LL;
          3'd5:    cmd_o.mul_op = MUL_M_LH;
          3'd6:    cmd_o.mul_op = MUL_M_HL;
          default: cmd_o.mul_op = MUL_M_HH;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          state_d = PWAIT;
        end
      end
      PWAIT: state_d = RINIT;
      RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ROOT;
      end
      ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = DONE;
        end
      end
      DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting result");

  a_event_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.action == ActEvent) |=> !cmd_o.out_load)
    else $error("event produced a result");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EV_SW) |-> (cnt_q < 4'(NumTrig)))
    else $error("row sweep ran past the last row");

  a_root_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ROOT) |-> !cmd_o.wr_en && !cmd_o.take)
    else $error("counter write during root search");

endmodule

FILE: hdl/trigger_bit_correlation_matrix_unit.sv
// channel   direction  payload      handshake
// in        input      tbcm_in_t    in_valid_i / in_stall_o
// out       output     tbcm_out_t   out_valid_o / out_stall_i
//
// An event is accepted, then the block sweeps the pair counter rows
// through the row RAM (read one row, write it back updated).
// An event arriving with the event counter full is accepted and changes nothing.
// A read uses a shared 20x20 multiplier for 12 products, then a
// 16-step shift-and-add root search, one result bit per cycle.
// Reset clears all counters at once through per-row valid bits.
// A stalled output holds its result; the block keeps working and waits only
// when the next result is ready to load.
module trigger_bit_correlation_matrix_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbcm_pkg::tbcm_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbcm_pkg::tbcm_out_t out_item_o
);
  import tbcm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tbcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbcm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

endmodule
